/* rtl/dsl_pkg.sv */
// Shared types, constants and conversion helpers for the DAC setpoint slew limiter.
package dsl_pkg;

  localparam int UV_W   = 25;
  localparam int STEP_W = 22;
  localparam int RATE_W = 26;
  localparam int CODE_W = 24;

  typedef enum logic [1:0] {
    KIND_SET_WRITE = 2'd0,
    KIND_SET_READ  = 2'd1,
    KIND_TICK      = 2'd2,
    KIND_READBACK  = 2'd3
  } kind_t;

  localparam logic [1:0] REG_RAMP_RATE = 2'd0;
  localparam logic [1:0] REG_MIN_LIMIT = 2'd1;
  localparam logic [1:0] REG_MAX_LIMIT = 2'd2;

  localparam logic signed [31:0] SET_MAX = 32'sd9999999;
  localparam logic signed [31:0] SET_MIN = -32'sd10000305;
  localparam logic [RATE_W-1:0] RATE_FLOOR = 26'd305;
  localparam logic [CODE_W-1:0] CODE_MID = 24'h800000;

  // floor(x / 10) = (x * DIV10_MULT) >> 30, exact for x below 2^26.
  localparam logic [26:0] DIV10_MULT = 27'd107374183;
  // floor(n * 2^23 / 10^7) = (n * CONV_MULT) >> 41, exact for n up to 2^24.
  localparam logic [40:0] CONV_MULT = 41'd1844674407371;
  // One code step is 78125 / 2^16 microvolts.
  localparam logic signed [41:0] UV_SCALE = 42'sd78125;

  typedef struct packed {
    logic write;
    logic read;
    logic cur_valid;
    logic sp_valid;
    logic sp_quant;
  } stage_flags_t;

  function automatic logic [UV_W-1:0] mag25(input logic signed [UV_W-1:0] x);
    return x[UV_W-1] ? UV_W'(-x) : UV_W'(x);
  endfunction

  function automatic logic [RATE_W-1:0] mag26(input logic signed [RATE_W-1:0] x);
    return x[RATE_W-1] ? RATE_W'(-x) : RATE_W'(x);
  endfunction

  // Signed code offset to microvolts, truncated toward zero.
  function automatic logic signed [UV_W-1:0] code_to_uv(input logic signed [UV_W-1:0] x);
    logic signed [41:0] p;
    p = $signed({{17{x[UV_W-1]}}, x}) * UV_SCALE;
    if (p[41]) begin
      p = p + 42'sd65535;
    end
    return p[40:16];
  endfunction

endpackage

/* rtl/dac_setpoint_slew_limiter.sv */
// Slew-rate-limited DAC setpoint control: state update and four-stage result pipeline.
// A result passes stages one to three, then the output register; the state update
// completes in the accept cycle. Throughput: one item per cycle unless output stalls.
// The microvolt to code conversion runs as a split multiply over the later stages.
// A stalled output holds the pipeline, and empty stages still fill behind it.
// Reset clears the channel state, the configuration registers and all stage valid bits.
module dac_setpoint_slew_limiter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [dsl_pkg::RATE_W-1:0]         cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [1:0]                         kind,
  input  logic signed [31:0]                 setpoint,
  input  logic [dsl_pkg::CODE_W-1:0]         readback_code,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               write_valid,
  output logic [dsl_pkg::CODE_W-1:0]         dac_code,
  output logic                               read_request,
  output logic                               current_valid,
  output logic signed [dsl_pkg::UV_W-1:0]    current_value,
  output logic                               setpoint_valid,
  output logic signed [dsl_pkg::UV_W-1:0]    setpoint_value
);
  import dsl_pkg::*;

  // Configuration.
  logic                      rate_zero;
  logic                      rate_pos;
  logic [STEP_W-1:0]         step;
  logic signed [UV_W-1:0]    min_limit;
  logic signed [UV_W-1:0]    max_limit;
  logic [RATE_W-1:0]         cfg_mag;
  logic [52:0]               cfg_div;

  // Channel state.
  logic signed [UV_W-1:0]    current_uv, current_uv_next;
  logic signed [UV_W-1:0]    target_uv, target_uv_next;
  logic                      ramping, ramping_next;
  logic                      write_acked, write_acked_next;
  logic                      first_step, first_step_next;
  logic                      final_write, final_write_next;

  // Pipeline control.
  logic                      v1, v2, v3, v4;
  logic                      en1, en2, en3, en4;
  logic                      accept;

  // Stage payloads.
  stage_flags_t              flags_next, s1_flags, s2_flags, s3_flags;
  logic signed [UV_W-1:0]    cur_out_next, s1_cur, s2_cur, s3_cur;
  logic signed [UV_W-1:0]    conv_x;
  logic                      s1_neg, s2_neg;
  logic [UV_W-1:0]           s1_mag;
  logic [44:0]               s2_pp_hi;
  logic [45:0]               s2_pp_lo;
  logic [65:0]               conv_sum;
  logic [UV_W-1:0]           conv_q;
  logic signed [UV_W-1:0]    s3_q;

  // Setpoint clamping and step arithmetic.
  logic signed [UV_W-1:0]    sp_clamp, sp_win;
  logic signed [RATE_W-1:0]  sp_diff;
  logic signed [RATE_W-1:0]  cur_up, cur_down, target_ext;
  logic signed [UV_W-1:0]    rb_uv;

  assign en4        = !v4 || !result_stall;
  assign en3        = !v3 || en4;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_stall = !en1;
  assign accept     = item_valid && en1;

  assign cfg_mag = mag26($signed(cfg_data));
  assign cfg_div = 53'(cfg_mag) * 53'(DIV10_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_zero <= 1'b1;
      rate_pos  <= 1'b0;
      step      <= '0;
      min_limit <= '0;
      max_limit <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RAMP_RATE: begin
          // Rates below the floor count as no ramping at all.
          if (cfg_mag < RATE_FLOOR) begin
            rate_zero <= 1'b1;
            rate_pos  <= 1'b0;
            step      <= '0;
          end else begin
            rate_zero <= 1'b0;
            rate_pos  <= !cfg_data[RATE_W-1];
            step      <= cfg_div[30+STEP_W-1:30];
          end
        end
        REG_MIN_LIMIT: min_limit <= cfg_data[UV_W-1:0];
        REG_MAX_LIMIT: max_limit <= cfg_data[UV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (setpoint > SET_MAX) begin
      sp_clamp = SET_MAX[UV_W-1:0];
    end else if (setpoint < SET_MIN) begin
      sp_clamp = SET_MIN[UV_W-1:0];
    end else begin
      sp_clamp = setpoint[UV_W-1:0];
    end
    sp_win = sp_clamp;
    if (min_limit < max_limit) begin
      if (sp_clamp > max_limit) begin
        sp_win = max_limit;
      end else if (sp_clamp < min_limit) begin
        sp_win = min_limit;
      end
    end
  end

  assign sp_diff    = $signed({sp_win[UV_W-1], sp_win}) - $signed({current_uv[UV_W-1], current_uv});
  assign target_ext = $signed({target_uv[UV_W-1], target_uv});
  assign cur_up     = $signed({current_uv[UV_W-1], current_uv}) + $signed({4'b0000, step});
  assign cur_down   = $signed({current_uv[UV_W-1], current_uv}) - $signed({4'b0000, step});
  // The code offset is the code with its top bit inverted.
  assign rb_uv      = code_to_uv($signed({~readback_code[CODE_W-1], ~readback_code[CODE_W-1],
                                          readback_code[CODE_W-2:0]}));

  always_comb begin
    current_uv_next  = current_uv;
    target_uv_next   = target_uv;
    ramping_next     = ramping;
    write_acked_next = write_acked;
    first_step_next  = first_step;
    final_write_next = final_write;
    flags_next       = '0;
    cur_out_next     = '0;
    conv_x           = sp_win;
    unique case (kind_t'(kind))
      KIND_SET_WRITE: begin
        flags_next.read = 1'b1;
        if (!ramping && (rate_zero || (rate_pos && mag25(sp_win) < mag25(current_uv)) ||
                         mag26(sp_diff) < RATE_W'(step))) begin
          flags_next.write = 1'b1;
        end else begin
          target_uv_next   = sp_win;
          ramping_next     = 1'b1;
          first_step_next  = 1'b1;
          final_write_next = 1'b0;
        end
      end
      KIND_SET_READ: begin
        flags_next.read = 1'b1;
      end
      KIND_TICK: begin
        if (ramping && write_acked) begin
          flags_next.write = 1'b1;
          flags_next.read  = 1'b1;
          write_acked_next = 1'b0;
          if (rate_zero) begin
            conv_x           = target_uv;
            final_write_next = 1'b1;
          end else if (target_uv > current_uv) begin
            if (cur_up >= target_ext) begin
              conv_x           = target_uv;
              final_write_next = 1'b1;
            end else begin
              conv_x = cur_up[UV_W-1:0];
            end
          end else begin
            if (cur_down <= target_ext) begin
              conv_x           = target_uv;
              final_write_next = 1'b1;
            end else begin
              conv_x = cur_down[UV_W-1:0];
            end
          end
        end
      end
      KIND_READBACK: begin
        current_uv_next      = rb_uv;
        write_acked_next     = 1'b1;
        cur_out_next         = rb_uv;
        flags_next.cur_valid = 1'b1;
        if (final_write) begin
          ramping_next = 1'b0;
        end
        if (!ramping_next) begin
          flags_next.sp_valid = 1'b1;
        end else if (first_step) begin
          // Report the target as the DAC will actually reproduce it.
          first_step_next     = 1'b0;
          flags_next.sp_valid = 1'b1;
          flags_next.sp_quant = 1'b1;
          conv_x              = target_uv;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_uv  <= '0;
      target_uv   <= '0;
      ramping     <= 1'b0;
      write_acked <= 1'b0;
      first_step  <= 1'b0;
      final_write <= 1'b0;
    end else if (accept) begin
      current_uv  <= current_uv_next;
      target_uv   <= target_uv_next;
      ramping     <= ramping_next;
      write_acked <= write_acked_next;
      first_step  <= first_step_next;
      final_write <= final_write_next;
    end
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= item_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
    end
  end

  assign conv_sum = {s2_pp_hi, 21'b0} + 66'(s2_pp_lo);
  assign conv_q   = conv_sum[65:41];

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_flags <= flags_next;
      s1_cur   <= cur_out_next;
      s1_neg   <= conv_x[UV_W-1];
      s1_mag   <= mag25(conv_x);
    end
    if (en2) begin
      s2_flags <= s1_flags;
      s2_cur   <= s1_cur;
      s2_neg   <= s1_neg;
      s2_pp_hi <= 45'(s1_mag) * 45'(CONV_MULT[40:21]);
      s2_pp_lo <= 46'(s1_mag) * 46'(CONV_MULT[20:0]);
    end
    if (en3) begin
      s3_flags <= s2_flags;
      s3_cur   <= s2_cur;
      s3_q     <= s2_neg ? $signed(UV_W'(-conv_q)) : $signed(conv_q);
    end
    if (en4) begin
      write_valid    <= s3_flags.write;
      dac_code       <= s3_flags.write ? s3_q[CODE_W-1:0] + CODE_MID : '0;
      read_request   <= s3_flags.read;
      current_valid  <= s3_flags.cur_valid;
      current_value  <= s3_cur;
      setpoint_valid <= s3_flags.sp_valid;
      if (!s3_flags.sp_valid) begin
        setpoint_value <= '0;
      end else if (s3_flags.sp_quant) begin
        setpoint_value <= code_to_uv(s3_q);
      end else begin
        setpoint_value <= s3_cur;
      end
    end
  end

  assign result_valid = v4;

endmodule

/* dv/tb_dac_setpoint_slew_limiter.sv */
// Self-checking testbench for the DAC setpoint slew limiter with a built-in channel predictor.
module tb_dac_setpoint_slew_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  import dsl_pkg::*;

  localparam longint CODE_HALF = 8388608;
  localparam longint FULL_SCALE_UV = 10000000;
  localparam int TICKS_PER_SEC = 10;
  localparam int PHASE_ITEMS = 150;
  localparam int FIXED_PHASES = 7;
  localparam int RANDOM_PHASES = 5;

  // Where a payload field is taken from when the item goes onto the bus.
  typedef enum {SRC_FIXED, SRC_ECHO, SRC_NEAR} src_t;

  typedef struct {
    kind_t             kind;
    logic signed [31:0] sp;
    logic [23:0]       rb;
    src_t              src;
  } dac_request_t;

  typedef struct {
    logic               write_valid;
    logic [23:0]        dac_code;
    logic               read_request;
    logic               current_valid;
    logic signed [24:0] current_value;
    logic               setpoint_valid;
    logic signed [24:0] setpoint_value;
  } dac_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_RAMP_RATE;
  logic [RATE_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] kind = KIND_SET_READ;
  logic signed [31:0] setpoint = '0;
  logic [CODE_W-1:0] readback_code = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic write_valid;
  logic [CODE_W-1:0] dac_code;
  logic read_request;
  logic current_valid;
  logic signed [UV_W-1:0] current_value;
  logic setpoint_valid;
  logic signed [UV_W-1:0] setpoint_value;

  dac_setpoint_slew_limiter dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .setpoint(setpoint), .readback_code(readback_code),
    .result_valid(result_valid), .result_stall(result_stall),
    .write_valid(write_valid), .dac_code(dac_code), .read_request(read_request),
    .current_valid(current_valid), .current_value(current_value),
    .setpoint_valid(setpoint_valid), .setpoint_value(setpoint_value)
  );

  // Channel model state and register copies.
  logic signed [25:0] rate_reg = '0;
  logic signed [24:0] lo_reg = '0;
  logic signed [24:0] hi_reg = '0;
  logic signed [31:0] now_uv = '0;
  logic signed [31:0] goal_uv = '0;
  bit ramp_on = 0;
  bit acked = 0;
  bit first_rb = 0;
  bit last_move = 0;
  logic [23:0] last_written_code = CODE_MID;

  dac_request_t dac_requests[$];
  dac_result_t results_due[$];
  dac_request_t bus_item;

  int mismatches = 0;
  int checked = 0;
  int dac_writes = 0;
  int ramps_done = 0;
  int settings = 0;
  int queued = 0;
  bit steady = 0;
  bit want_hold = 0;
  int hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint code_of(longint uv);
    return uv * CODE_HALF / FULL_SCALE_UV + CODE_HALF;
  endfunction

  function automatic longint uv_of(longint code);
    return (code - CODE_HALF) * FULL_SCALE_UV / CODE_HALF;
  endfunction

  function automatic longint step_size();
    return mag(rate_reg) / TICKS_PER_SEC;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [25:0] val);
    logic signed [25:0] r;
    r = val;
    case (idx)
      REG_RAMP_RATE: rate_reg = (mag(r) < 305) ? '0 : r;
      REG_MIN_LIMIT: lo_reg = val[24:0];
      REG_MAX_LIMIT: hi_reg = val[24:0];
      default: ;
    endcase
  endfunction

  function automatic void issue_write(ref dac_result_t r, input longint uv);
    r.write_valid = 1'b1;
    r.dac_code = 24'(code_of(uv));
    last_written_code = r.dac_code;
    dac_writes++;
  endfunction

  // Advances the channel by one transfer and queues the result it must produce.
  function automatic void step_channel(dac_request_t it);
    dac_result_t r;
    longint v;
    longint stride;
    r = '{default: '0};
    stride = step_size();
    case (it.kind)
      KIND_SET_WRITE: begin
        v = it.sp;
        if (v > SET_MAX) v = SET_MAX;
        if (v < SET_MIN) v = SET_MIN;
        if (lo_reg < hi_reg) begin
          if (v > hi_reg) v = hi_reg;
          if (v < lo_reg) v = lo_reg;
        end
        if (!ramp_on && (rate_reg == 0 || (rate_reg > 0 && mag(v) < mag(now_uv)) ||
                         mag(v - now_uv) < stride)) begin
          issue_write(r, v);
        end else begin
          goal_uv = v;
          ramp_on = 1;
          first_rb = 1;
          last_move = 0;
        end
        r.read_request = 1'b1;
      end
      KIND_SET_READ: r.read_request = 1'b1;
      KIND_TICK: begin
        if (ramp_on && acked) begin
          if (rate_reg == 0) begin
            v = goal_uv;
            last_move = 1;
          end else if (goal_uv > now_uv) begin
            v = now_uv + stride;
            if (v >= goal_uv) begin
              v = goal_uv;
              last_move = 1;
            end
          end else begin
            v = now_uv - stride;
            if (v <= goal_uv) begin
              v = goal_uv;
              last_move = 1;
            end
          end
          issue_write(r, v);
          r.read_request = 1'b1;
          acked = 0;
        end
      end
      default: begin
        now_uv = 32'(uv_of(longint'(it.rb)));
        acked = 1;
        if (last_move && ramp_on) ramps_done++;
        if (last_move) ramp_on = 0;
        r.current_valid = 1'b1;
        r.current_value = 25'(now_uv);
        if (!ramp_on) begin
          r.setpoint_valid = 1'b1;
          r.setpoint_value = 25'(now_uv);
        end else if (first_rb) begin
          first_rb = 0;
          r.setpoint_valid = 1'b1;
          r.setpoint_value = 25'(uv_of(code_of(goal_uv)));
        end
      end
    endcase
    results_due.push_back(r);
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s: got %h, want %h", name, got, want));
  endtask

  function automatic void push(kind_t k, logic signed [31:0] sp, logic [23:0] rb, src_t src);
    dac_request_t it;
    it.kind = k;
    it.sp = sp;
    it.rb = rb;
    it.src = src;
    dac_requests.push_back(it);
    queued++;
  endfunction

  function automatic logic signed [31:0] pick_setpoint();
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return SET_MAX;
          3: return SET_MIN;
          default: return '0;
        endcase
      end
      default: return $signed(32'($urandom_range(0, 22000000))) - 32'sd11000000;
    endcase
  endfunction

  function automatic void push_noise();
    push(kind_t'($urandom_range(3)), $urandom, 24'($urandom), SRC_FIXED);
  endfunction

  // A setpoint followed by tick / readback pairs, as the control loop would issue them.
  function automatic void ramp_run(int steps);
    push(KIND_SET_WRITE, pick_setpoint(), '0, ($urandom_range(3) == 0) ? SRC_NEAR : SRC_FIXED);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(9) == 0) push_noise();
      push(KIND_TICK, $urandom, 24'($urandom), SRC_FIXED);
      if ($urandom_range(7) == 0) push(KIND_SET_READ, $urandom, 24'($urandom), SRC_FIXED);
      push(KIND_READBACK, $urandom, '0, SRC_ECHO);
      if ($urandom_range(19) == 0) push(KIND_SET_WRITE, pick_setpoint(), '0, SRC_FIXED);
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [25:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    apply_reg(idx, val);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_settings(int rate, int lo, int hi);
    write_reg(REG_RAMP_RATE, 26'(rate));
    write_reg(REG_MIN_LIMIT, 26'(lo));
    write_reg(REG_MAX_LIMIT, 26'(hi));
    settings++;
  endtask

  task automatic settle();
    while (dac_requests.size() != 0 || item_valid || results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sender: one item on the bus at a time, held until its transfer.
  always @(posedge clk) begin
    dac_request_t nxt;
    bit take;
    longint span;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) step_channel(bus_item);
      if (!item_valid || !item_stall) begin
        take = dac_requests.size() != 0 && (steady || $urandom_range(99) >= 37);
        if (take) begin
          nxt = dac_requests.pop_front();
          // Echoed readbacks and near setpoints depend on the state after the last transfer.
          if (nxt.src == SRC_ECHO) begin
            nxt.rb = last_written_code;
            if ($urandom_range(7) == 0) nxt.rb = last_written_code + 24'd1;
          end else if (nxt.src == SRC_NEAR) begin
            span = step_size() + 50;
            nxt.sp = 32'(longint'(now_uv) + longint'($urandom_range(0, 32'(2 * span))) - span);
          end
          bus_item = nxt;
          kind <= nxt.kind;
          setpoint <= nxt.sp;
          readback_code <= nxt.rb;
        end
        item_valid <= take;
      end
    end
  end

  // Receiver: checks each result transfer and drives the stall.
  always @(posedge clk) begin
    dac_result_t due;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (results_due.size() == 0) begin
          log_mismatch("result transfer with no result due");
        end else begin
          due = results_due.pop_front();
          checked++;
          cmp_field("write_valid", write_valid, due.write_valid);
          cmp_field("dac_code", dac_code, due.dac_code);
          cmp_field("read_request", read_request, due.read_request);
          cmp_field("current_valid", current_valid, due.current_valid);
          cmp_field("current_value", current_value, due.current_value);
          cmp_field("setpoint_valid", setpoint_valid, due.setpoint_valid);
          cmp_field("setpoint_value", setpoint_value, due.setpoint_value);
        end
      end
      if (want_hold) begin
        hold_left = 400;
        want_hold = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !steady && $urandom_range(99) < 37;
      end
    end
  end

  initial begin
    int phase_rate[FIXED_PHASES] = '{0, 304, -20000000, 20000000, 305, -305, -304};
    int phase_lo[FIXED_PHASES] = '{-10000305, 5000000, -2000000, 0, 1000, 9999999, -10000305};
    int phase_hi[FIXED_PHASES] = '{9999999, -5000000, 3000000, 0, 1001, 9999999, 0};
    int rate;
    int lo;
    int hi;
    int goal_count;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // First ramp after reset: no step may be taken before a readback arrives.
    write_settings(1000000, -10000305, 9999999);
    push(KIND_SET_WRITE, 32'sd300000, '0, SRC_FIXED);
    push(KIND_TICK, '0, '0, SRC_FIXED);
    push(KIND_SET_READ, '0, '0, SRC_FIXED);
    push(KIND_READBACK, '0, CODE_MID, SRC_FIXED);
    for (int i = 0; i < 3; i++) begin
      push(KIND_TICK, '1, '1, SRC_FIXED);
      push(KIND_READBACK, '0, '0, SRC_ECHO);
    end
    push(KIND_TICK, '0, '0, SRC_FIXED);
    push(KIND_READBACK, '0, 24'hffffff, SRC_FIXED);
    push(KIND_SET_WRITE, 32'sh7fffffff, '0, SRC_FIXED);
    push(KIND_READBACK, '0, 24'h000000, SRC_FIXED);
    push(KIND_SET_WRITE, 32'sh80000000, '0, SRC_FIXED);
    push(KIND_SET_WRITE, 32'sd0, '0, SRC_FIXED);
    push(KIND_READBACK, '0, CODE_MID, SRC_FIXED);
    push(KIND_SET_WRITE, -32'sd2000000, '0, SRC_FIXED);
    push(KIND_TICK, '0, '0, SRC_FIXED);
    // A new setpoint during a ramp moves the target and rearms the first-step report.
    push(KIND_SET_WRITE, -32'sd150000, '0, SRC_FIXED);
    push(KIND_READBACK, '0, '0, SRC_ECHO);
    push(KIND_TICK, '0, '0, SRC_FIXED);
    push(KIND_READBACK, '0, '0, SRC_ECHO);
    settle();

    for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        rate = phase_rate[p];
        lo = phase_lo[p];
        hi = phase_hi[p];
      end else begin
        rate = ($urandom_range(3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 20000000);
        if ($urandom_range(1)) rate = -rate;
        lo = $urandom_range(0, 20000304) - 10000305;
        hi = $urandom_range(0, 20000304) - 10000305;
      end
      write_settings(rate, lo, hi);
      goal_count = queued + PHASE_ITEMS;
      while (queued < goal_count) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 3)) push_noise();
        end else begin
          ramp_run($urandom_range(2, 12));
        end
      end
      steady = (p == 3);
      // Receiver holds off long enough for the block to back up into its input.
      if (p == 2) want_hold = 1;
      settle();
      steady = 0;
    end

    $display("Checked %0d result transfers over %0d register settings.", checked, settings);
    $display("Predicted %0d DAC writes and %0d completed ramps.", dac_writes, ramps_done);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
